FILE: hdl/i2cmbe_pkg.sv
// Shared types, codes and tables for the I2C master bit engine.
package i2cmbe_pkg;

    // Command codes carried in the kind field
    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_START    = 3'd1;
    localparam logic [2:0] KIND_STOP     = 3'd2;
    localparam logic [2:0] KIND_WRITE    = 3'd3;
    localparam logic [2:0] KIND_READ     = 3'd4;
    localparam logic [2:0] KIND_WAIT_ACK = 3'd5;
    localparam logic [2:0] KIND_SEND_ACK = 3'd6;

    // Register indexes (address bit 2 of the APB port)
    localparam logic REG_TICKS_PER_US = 1'b0;
    localparam logic REG_ACK_TIMEOUT  = 1'b1;

    localparam logic [9:0] TICKS_PER_US_RESET = 10'd16;
    localparam logic [7:0] ACK_TIMEOUT_RESET  = 8'd250;
    localparam logic [2:0] US_COUNT_MAX       = 3'd7;

    // Sequencer phases, one-hot
    typedef enum logic [21:0] {
        PH_IDLE = 22'h000001,
        PH_S0   = 22'h000002,
        PH_S1   = 22'h000004,
        PH_S2   = 22'h000008,
        PH_P0   = 22'h000010,
        PH_P1   = 22'h000020,
        PH_P2   = 22'h000040,
        PH_P3   = 22'h000080,
        PH_A0   = 22'h000100,
        PH_A1   = 22'h000200,
        PH_A2   = 22'h000400,
        PH_A3   = 22'h000800,
        PH_W0   = 22'h001000,
        PH_W1   = 22'h002000,
        PH_W2   = 22'h004000,
        PH_W3   = 22'h008000,
        PH_B0   = 22'h010000,
        PH_B1   = 22'h020000,
        PH_B2   = 22'h040000,
        PH_B3   = 22'h080000,
        PH_R1   = 22'h100000,
        PH_R2   = 22'h200000
    } phase_t;

    // Bus line registers
    typedef struct packed {
        logic en;
        logic sda;
        logic scl;
    } lines_t;

    localparam lines_t LINES_RESET = '{en: 1'b1, sda: 1'b1, scl: 1'b1};

    typedef struct packed {
        logic [9:0] ticks_per_us;
        logic [7:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic       sda_line;
        logic       ack_wanted;
        logic [7:0] data_byte;
        logic [2:0] kind;
    } item_t;

    typedef struct packed {
        logic       ack_failed;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        lines_t     lines;
    } result_t;

    // Hold time of each phase in microseconds
    function automatic logic [2:0] hold_us(input phase_t ph);
        logic [2:0] d;
        case (ph)
            PH_S0:   d = 3'd5;
            PH_S1:   d = 3'd6;
            PH_P2:   d = 3'd6;
            PH_P3:   d = 3'd6;
            PH_A1:   d = 3'd2;
            PH_A2:   d = 3'd5;
            PH_W0:   d = 3'd1;
            PH_W1:   d = 3'd1;
            PH_B2:   d = 3'd2;
            PH_B3:   d = 3'd2;
            PH_R1:   d = 3'd2;
            PH_R2:   d = 3'd1;
            default: d = 3'd0;
        endcase
        return d;
    endfunction

    // First phase of each command
    function automatic phase_t first_phase(input logic [2:0] kind);
        phase_t p;
        case (kind)
            KIND_START:    p = PH_S0;
            KIND_STOP:     p = PH_P0;
            KIND_WRITE:    p = PH_B0;
            KIND_READ:     p = PH_R1;
            KIND_WAIT_ACK: p = PH_W0;
            KIND_SEND_ACK: p = PH_A0;
            default:       p = PH_IDLE;
        endcase
        return p;
    endfunction

endpackage

FILE: hdl/i2c_master_bit_engine_unit.sv
// Each result is registered in the output buffer before it is presented on m_tvalid.
// One tick per cycle unless the buffer is full; phase, counters, lines update in one pass.
// A two-entry output buffer keeps s_tready high while one result waits downstream.
// Reset: phase idle, SCL and SDA high with SDA driven, counters and read byte zero,
// ticks_per_us 16, ack_timeout 250; no clearing pass, ready in the first cycle.
module i2c_master_bit_engine_unit
    import i2cmbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // kind[2:0], data_byte[10:3], ack_wanted[11], sda_line[12]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // scl_level[0], sda_level[1], sda_enable[2], busy_res[3],
                                  // done_res[4], read_data[12:5], ack_failed[13]
);

    cfg_t    cfg;
    item_t   item;
    result_t res;
    result_t out_res;
    logic    accept;

    assign accept = s_tvalid & s_tready;

    // Unpack the incoming tick
    assign item.kind       = s_tdata[2:0];
    assign item.data_byte  = s_tdata[10:3];
    assign item.ack_wanted = s_tdata[11];
    assign item.sda_line   = s_tdata[12];

    i2cmbe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2cmbe_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .item   (item),
        .res    (res)
    );

    i2cmbe_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .din       (res),
        .has_room  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .dout      (out_res)
    );

    // Pack the result
    assign m_tdata = {2'b00, out_res.ack_failed, out_res.read_data, out_res.done_res,
                      out_res.busy_res, out_res.lines.en, out_res.lines.sda,
                      out_res.lines.scl};

endmodule

FILE: hdl/i2cmbe_cfg.sv
// APB register bank holding the tick scale and the ack timeout.
module i2cmbe_cfg
    import i2cmbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [9:0] ticks_per_us_reg;
    logic [7:0] ack_timeout_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // Write on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_us_reg <= TICKS_PER_US_RESET;
            ack_timeout_reg  <= ACK_TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_TICKS_PER_US: ticks_per_us_reg <= pwdata[9:0];
                REG_ACK_TIMEOUT:  ack_timeout_reg  <= pwdata[7:0];
                default:          ticks_per_us_reg <= ticks_per_us_reg;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (paddr[2])
            REG_TICKS_PER_US: prdata = {22'd0, ticks_per_us_reg};
            REG_ACK_TIMEOUT:  prdata = {24'd0, ack_timeout_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.ticks_per_us = ticks_per_us_reg;
    assign cfg.ack_timeout  = ack_timeout_reg;

endmodule

FILE: hdl/i2cmbe_seq.sv
// Phase sequencer: advances the bus state by one tick per transfer.
module i2cmbe_seq
    import i2cmbe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    accept,
    input  item_t   item,
    output result_t res
);

    phase_t     phase_reg, phase_next;
    logic [2:0] command_reg, command_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_reg, shift_next;
    logic [9:0] tick_reg, tick_next;
    logic [2:0] us_reg, us_next;
    logic [7:0] poll_reg, poll_next;
    logic       ack_flag_reg, ack_flag_next;
    logic       choice_reg, choice_next;
    logic [7:0] read_reg, read_next;
    lines_t     lines_reg, lines_next;
    logic       done;
    logic       entered;
    logic       elapsed;
    logic [9:0] tpu_eff;
    logic [2:0] hold;

    assign tpu_eff = (cfg.ticks_per_us == 10'd0) ? 10'd1 : cfg.ticks_per_us;
    assign hold    = hold_us(phase_reg);
    assign elapsed = (hold == 3'd0) ? ((tick_reg != 10'd0) || (us_reg != 3'd0))
                                    : (us_reg >= hold);

    // Work out the next state for this tick
    always_comb
    begin
        phase_next     = phase_reg;
        command_next   = command_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        tick_next      = tick_reg;
        us_next        = us_reg;
        poll_next      = poll_reg;
        ack_flag_next  = ack_flag_reg;
        choice_next    = choice_reg;
        read_next      = read_reg;
        lines_next     = lines_reg;
        done           = 1'b0;
        entered        = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            // Take a new command
            if ((item.kind != KIND_NONE) && (first_phase(item.kind) != PH_IDLE))
            begin
                command_next   = item.kind;
                bit_count_next = 4'd0;
                poll_next      = 8'd0;
                choice_next    = item.ack_wanted;
                shift_next     = (item.kind == KIND_WRITE) ? item.data_byte : 8'd0;
                if (item.kind == KIND_WAIT_ACK)
                    ack_flag_next = 1'b0;
                phase_next = first_phase(item.kind);
                entered    = 1'b1;
            end
        end
        else if ((phase_reg != PH_W2) && elapsed)
        begin
            // Step to the following phase
            entered = 1'b1;
            case (phase_reg)
                PH_S0: phase_next = PH_S1;
                PH_S1: phase_next = PH_S2;
                PH_P0: phase_next = PH_P1;
                PH_P1: phase_next = PH_P2;
                PH_P2: phase_next = PH_P3;
                PH_A0: phase_next = PH_A1;
                PH_A1: phase_next = PH_A2;
                PH_A2: phase_next = PH_A3;
                PH_W0: phase_next = PH_W1;
                PH_W1: phase_next = PH_W2;
                PH_B0: phase_next = PH_B1;
                PH_B1: phase_next = PH_B2;
                PH_B2: phase_next = PH_B3;
                PH_B3:
                begin
                    bit_count_next = bit_count_reg + 4'd1;
                    if (!bit_count_next[3])
                        phase_next = PH_B1;
                    else
                        done = 1'b1;
                end
                PH_R1: phase_next = PH_R2;
                PH_R2:
                begin
                    bit_count_next = bit_count_reg + 4'd1;
                    phase_next = bit_count_next[3] ? PH_A0 : PH_R1;
                end
                default: done = 1'b1;
            endcase
            if (done)
            begin
                entered    = 1'b0;
                phase_next = PH_IDLE;
                if (command_reg == KIND_READ)
                    read_next = shift_reg;
            end
        end

        // Apply the line changes of the phase entered
        if (entered)
        begin
            tick_next = 10'd0;
            us_next   = 3'd0;
            case (phase_next)
                PH_S0:
                begin
                    lines_next.en  = 1'b1;
                    lines_next.scl = 1'b1;
                    lines_next.sda = 1'b1;
                end
                PH_S1: lines_next.sda = 1'b0;
                PH_S2: lines_next.scl = 1'b0;
                PH_P0, PH_A0, PH_B0:
                begin
                    lines_next.en  = 1'b1;
                    lines_next.scl = 1'b0;
                end
                PH_P1: lines_next.sda = 1'b0;
                PH_P2, PH_A2, PH_W1, PH_B2: lines_next.scl = 1'b1;
                PH_P3: lines_next.sda = 1'b1;
                PH_A1: lines_next.sda = ~choice_next;
                PH_A3, PH_W3, PH_B3: lines_next.scl = 1'b0;
                PH_W0:
                begin
                    lines_next.en  = 1'b0;
                    lines_next.sda = 1'b1;
                end
                PH_B1:
                begin
                    lines_next.sda = shift_next[7];
                    shift_next     = {shift_next[6:0], 1'b0};
                end
                PH_R1:
                begin
                    lines_next.en  = 1'b0;
                    lines_next.scl = 1'b0;
                end
                PH_R2:
                begin
                    lines_next.scl = 1'b1;
                    shift_next     = {shift_next[6:0], item.sda_line};
                end
                default: lines_next = lines_next;
            endcase
        end

        // Poll for the slave ack
        if (phase_next == PH_W2)
        begin
            if (!item.sda_line)
            begin
                phase_next     = PH_W3;
                lines_next.scl = 1'b0;
                tick_next      = 10'd0;
                us_next        = 3'd0;
            end
            else if (poll_reg >= cfg.ack_timeout)
            begin
                ack_flag_next  = 1'b1;
                phase_next     = PH_P0;
                lines_next.en  = 1'b1;
                lines_next.scl = 1'b0;
                tick_next      = 10'd0;
                us_next        = 3'd0;
            end
            else
            begin
                poll_next = poll_reg + 8'd1;
            end
        end

        // Count the tick
        if ((phase_next != PH_IDLE) && (phase_next != PH_W2))
        begin
            tick_next = tick_next + 10'd1;
            if (tick_next >= tpu_eff)
            begin
                tick_next = 10'd0;
                if (us_next != US_COUNT_MAX)
                    us_next = us_next + 3'd1;
            end
        end
    end

    // Hold the state between transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            command_reg   <= KIND_NONE;
            bit_count_reg <= 4'd0;
            shift_reg     <= 8'd0;
            tick_reg      <= 10'd0;
            us_reg        <= 3'd0;
            poll_reg      <= 8'd0;
            ack_flag_reg  <= 1'b0;
            choice_reg    <= 1'b0;
            read_reg      <= 8'd0;
            lines_reg     <= LINES_RESET;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            command_reg   <= command_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            tick_reg      <= tick_next;
            us_reg        <= us_next;
            poll_reg      <= poll_next;
            ack_flag_reg  <= ack_flag_next;
            choice_reg    <= choice_next;
            read_reg      <= read_next;
            lines_reg     <= lines_next;
        end
    end

    assign res.lines      = lines_next;
    assign res.busy_res   = (phase_next != PH_IDLE);
    assign res.done_res   = done;
    assign res.read_data  = read_next;
    assign res.ack_failed = ack_flag_next;

    // A completed command leaves the engine idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.done_res) |=> (phase_reg == PH_IDLE))
        else $error("done without return to idle");

    // SDA is released while waiting for the ack
    a_w2_released: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_W2) |-> !lines_reg.en)
        else $error("SDA driven during ack poll");

    // A wait ack command clears the failure flag
    a_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_reg == PH_IDLE) && (item.kind == KIND_WAIT_ACK))
        |=> !ack_flag_reg)
        else $error("ack failure flag not cleared");

    // Bit counter stays within one byte
    a_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= 4'd8)
        else $error("bit counter overrun");

endmodule

FILE: hdl/i2cmbe_obuf.sv
// Two-entry output buffer between the sequencer and the result stream.
module i2cmbe_obuf
    import i2cmbe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t din,
    output logic    has_room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t dout
);

    result_t    head_reg;
    result_t    tail_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop       = (cnt_reg != 2'd0) && out_ready;
    assign has_room  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign dout      = head_reg;
    assign cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    // Move payload through the two slots
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (cnt_reg == 2'd2)
                head_reg <= tail_reg;
            else if (push)
                head_reg <= din;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
                head_reg <= din;
            else
                tail_reg <= din;
        end
    end

endmodule
